FILE: rtl/core/d64bid_pkg.sv
// shared types and constants for the decimal64 bid unpack pipeline
`default_nettype none

package d64bid_pkg;

  localparam int RawWidth    = 64;
  localparam int CoefWidth   = 54;
  localparam int ExpWidth    = 10;
  localparam int DigitWidth  = 5;
  localparam int CoefDigits  = 16;
  localparam int BcdWidth    = 4 * CoefDigits;
  localparam int OutWidth    = 72;
  localparam int ClassWidth  = 2;

  localparam logic [CoefWidth-1:0] CoefMax = 54'd9999999999999999;
  localparam logic [ExpWidth-1:0]  ExpBias = 10'd398;

  localparam logic RegStripZeros = 1'b0;

  typedef enum logic [ClassWidth-1:0] {
    ClsNormal  = 2'd0,
    ClsInvalid = 2'd1,
    ClsNan     = 2'd2,
    ClsInf     = 2'd3
  } value_class_e;

  typedef struct packed {
    logic                       sign;
    value_class_e               cls;
    logic                       strip;
    logic                       nz;
    logic signed [ExpWidth-1:0] exp;
    logic [3:0]                 tz;
    logic [DigitWidth-1:0]      nd;
    logic [CoefWidth-1:0]       bin;
    logic [BcdWidth-1:0]        bcd;
  } pipe_t;

endpackage

`default_nettype wire

FILE: rtl/core/decimal64_bid_unpack_normalize.sv
// decimal64 bid unpack with optional trailing zero strip, fully pipelined
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid / tready           tdata[63:0] raw_word
//  m_axis    out  tvalid / tready           tdata sign, coef, exp, digits; tuser class
//  apb       in   psel, penable, pready=1   reg 0 strip_zeros at byte address 0
//
// one beat per cycle sustained while m_axis_tready stays high; stages in order:
// decode, the binary to bcd conversion (9 stages of 6 shift steps), zero count,
// shift, and the bcd to binary rebuild (8 stages of 2 digits)
// each stage holds its beat while the next one is full and cannot advance, so stalls drop nothing
// reset empties the pipeline and sets strip_zeros to 1
`default_nettype none

module decimal64_bid_unpack_normalize import d64bid_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  input  wire logic [RawWidth-1:0]   s_axis_tdata_i,   // raw_word
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output      logic [OutWidth-1:0]   m_axis_tdata_o,   // sign_bit, coefficient, exponent,
                                                       // digit_count, zero fill
  output      logic [ClassWidth-1:0] m_axis_tuser_o,   // value_class
  input  wire logic                  psel_i,
  input  wire logic                  penable_i,
  input  wire logic                  pwrite_i,
  input  wire logic [2:0]            paddr_i,
  input  wire logic [31:0]           pwdata_i,
  output      logic [31:0]           prdata_o,
  output      logic                  pready_o
);

  localparam int DabBits    = CoefWidth;
  localparam int DabSteps   = 6;
  localparam int DabStages  = DabBits / DabSteps;
  localparam int HornStages = CoefDigits / 2;
  localparam int CountIdx   = DabStages + 1;
  localparam int ShiftIdx   = DabStages + 2;
  localparam int NumStages  = DabStages + 3 + HornStages;

  logic strip_zeros_q;
  logic strip_zeros_d;

  pipe_t                pipe_q [NumStages];
  pipe_t                pipe_d [NumStages];
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] adv;

  // configuration port
  assign pready_o = 1'b1;

  always_comb begin
    strip_zeros_d = strip_zeros_q;
    if (psel_i && penable_i && pwrite_i && (paddr_i[2] == RegStripZeros)) begin
      strip_zeros_d = pwdata_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_zeros_q <= 1'b1;
    end else begin
      strip_zeros_q <= strip_zeros_d;
    end
  end

  assign prdata_o = (paddr_i[2] == RegStripZeros) ? {31'd0, strip_zeros_q} : 32'd0;

  // advance chain
  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready_o = adv[0];

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    if (k == 0) begin : g_decode
      always_comb begin
        logic [ExpWidth-1:0]  bexp;
        logic [CoefWidth-1:0] m;
        pipe_d[k] = '0;
        pipe_d[k].sign  = s_axis_tdata_i[63];
        pipe_d[k].strip = strip_zeros_q;
        pipe_d[k].nd    = DigitWidth'(1);
        if (s_axis_tdata_i[62:61] == 2'b11) begin
          bexp = s_axis_tdata_i[60:51];
          m    = {3'b100, s_axis_tdata_i[50:0]};
        end else begin
          bexp = s_axis_tdata_i[62:53];
          m    = {1'b0, s_axis_tdata_i[52:0]};
        end
        if (s_axis_tdata_i[62:59] == 4'hf) begin
          pipe_d[k].cls = s_axis_tdata_i[58] ? ClsNan : ClsInf;
        end else if (m > CoefMax) begin
          pipe_d[k].cls = ClsInvalid;
        end else begin
          pipe_d[k].cls = ClsNormal;
          pipe_d[k].bin = m;
          pipe_d[k].nz  = (m != '0);
          if (!(strip_zeros_q && (m == '0))) begin
            pipe_d[k].exp = $signed(bexp - ExpBias);
          end
        end
      end
    end else if (k <= DabStages) begin : g_dabble
      always_comb begin
        logic [BcdWidth-1:0]  b;
        logic [CoefWidth-1:0] r;
        pipe_d[k] = pipe_q[k-1];
        b = pipe_q[k-1].bcd;
        r = pipe_q[k-1].bin;
        for (int i = 0; i < DabSteps; i++) begin
          for (int g = 0; g < CoefDigits; g++) begin
            if (b[4*g +: 4] >= 4'd5) begin
              b[4*g +: 4] = b[4*g +: 4] + 4'd3;
            end
          end
          b = {b[BcdWidth-2:0], r[CoefWidth-1]};
          r = {r[CoefWidth-2:0], 1'b0};
        end
        pipe_d[k].bcd = b;
        pipe_d[k].bin = r;
      end
    end else if (k == CountIdx) begin : g_count
      always_comb begin
        logic found;
        pipe_d[k] = pipe_q[k-1];
        found = 1'b0;
        pipe_d[k].tz = '0;
        pipe_d[k].nd = DigitWidth'(1);
        for (int g = 0; g < CoefDigits; g++) begin
          if (pipe_q[k-1].bcd[4*g +: 4] != 4'd0) begin
            pipe_d[k].nd = DigitWidth'(g + 1);
            if (!found) begin
              found = 1'b1;
              if (pipe_q[k-1].strip && pipe_q[k-1].nz) begin
                pipe_d[k].tz = 4'(g);
              end
            end
          end
        end
      end
    end else if (k == ShiftIdx) begin : g_shift
      always_comb begin
        pipe_d[k] = pipe_q[k-1];
        pipe_d[k].bcd = pipe_q[k-1].bcd >> {pipe_q[k-1].tz, 2'b00};
        pipe_d[k].exp = pipe_q[k-1].exp + $signed({6'd0, pipe_q[k-1].tz});
        pipe_d[k].nd  = pipe_q[k-1].nd - {1'b0, pipe_q[k-1].tz};
        pipe_d[k].bin = '0;
      end
    end else begin : g_horner
      localparam int J  = k - ShiftIdx - 1;
      localparam int Hi = 4 * (CoefDigits - 1 - 2 * J);
      localparam int Lo = Hi - 4;
      always_comb begin
        logic [CoefWidth-1:0] acc;
        logic [3:0]           hi;
        logic [3:0]           lo;
        pipe_d[k] = pipe_q[k-1];
        acc = pipe_q[k-1].bin;
        hi  = pipe_q[k-1].bcd[Hi +: 4];
        lo  = pipe_q[k-1].bcd[Lo +: 4];
        pipe_d[k].bin = (acc << 6) + (acc << 5) + (acc << 2)
                      + CoefWidth'({hi, 3'b000}) + CoefWidth'({hi, 1'b0})
                      + CoefWidth'(lo);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv[k]) begin
        valid_q[k] <= (k == 0) ? s_axis_tvalid_i : valid_q[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign m_axis_tvalid_o = valid_q[NumStages-1];
  assign m_axis_tuser_o  = pipe_q[NumStages-1].cls;
  assign m_axis_tdata_o  = {2'b00,
                            pipe_q[NumStages-1].nd,
                            pipe_q[NumStages-1].exp,
                            pipe_q[NumStages-1].bin,
                            pipe_q[NumStages-1].sign};

endmodule

`default_nettype wire

FILE: rtl/core/d64bid_checker.sv
// port level checks for the decimal64 bid unpack pipeline
`default_nettype none

module d64bid_port_checks import d64bid_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OutWidth-1:0]   m_axis_tdata_o,
  input wire logic [ClassWidth-1:0] m_axis_tuser_o
);

  a_special_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ClsNormal) |->
      (m_axis_tdata_o[54:1] == '0) && (m_axis_tdata_o[64:55] == '0)
      && (m_axis_tdata_o[69:65] == 5'd1))
    else $error("special or invalid beat with nonzero payload");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[69:65] >= 5'd1) && (m_axis_tdata_o[69:65] <= 5'd16))
    else $error("digit count out of range");

  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[64:55]) >= -10'sd398)
                        && ($signed(m_axis_tdata_o[64:55]) <= 10'sd384))
    else $error("exponent out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output beat changed");

endmodule

bind decimal64_bid_unpack_normalize d64bid_port_checks u_checker (.*);

`default_nettype wire
